@@ rtl/core/pdhrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdhrc_pkg : shared types and constants for the heading rotation controller
// Payload structs, register indexes, state encoding, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pdhrc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // CORDIC datapath widths: 33-bit deltas grow by the CORDIC gain, angles in Q.30
  localparam int DELTA_W = 33;
  localparam int XY_W    = 36;
  localparam int Z_W     = 35;
  localparam int BEAR_W  = 17;

  localparam logic [15:0]            PI_Q12 = 16'd12868;
  localparam logic signed [Z_W-1:0]  PI_Q30 = 35'sd3373259426;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_POSE  = 1'b1;

  typedef enum logic [2:0] {
    REG_TARGET_X  = 3'd0,
    REG_TARGET_Y  = 3'd1,
    REG_GAIN_P    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_STOP_THR  = 3'd4
  } pdhrc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROTATE,
    ST_MULP,
    ST_MULD,
    ST_EMIT
  } pdhrc_state_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] yaw;
  } pdhrc_in_t;

  typedef struct packed {
    logic signed [15:0] turn_rate;
    logic               stopped;
  } pdhrc_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pdhrc_cordic_stat_t;

  // atan(2^-i) in Q.30
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 35'sd843314856;
      5'd1:    v = 35'sd497837829;
      5'd2:    v = 35'sd263043836;
      5'd3:    v = 35'sd133525158;
      5'd4:    v = 35'sd67021686;
      5'd5:    v = 35'sd33543515;
      5'd6:    v = 35'sd16775850;
      5'd7:    v = 35'sd8388437;
      5'd8:    v = 35'sd4194282;
      5'd9:    v = 35'sd2097149;
      5'd10:   v = 35'sd1048575;
      5'd11:   v = 35'sd524287;
      5'd12:   v = 35'sd262143;
      5'd13:   v = 35'sd131071;
      5'd14:   v = 35'sd65535;
      5'd15:   v = 35'sd32767;
      5'd16:   v = 35'sd16383;
      5'd17:   v = 35'sd8191;
      5'd18:   v = 35'sd4095;
      5'd19:   v = 35'sd2047;
      5'd20:   v = 35'sd1023;
      5'd21:   v = 35'sd511;
      5'd22:   v = 35'sd255;
      5'd23:   v = 35'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/pd_heading_rotation_controller_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pd_heading_rotation_controller_core : rotate-to-target PD heading controller
// Bearing by iterative CORDIC, PD law through one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel. kind = start arms the block and presets both
//           errors to pi (no result). kind = pose gives one result while armed;
//           a pose while disarmed is dropped.
//   out_* : valid/ready channel carrying turn_rate (Q4.12) and stopped.
//   cfg_* : write-only registers (target, gains, stop threshold), written idle.
// Timing: in_ready is high only when the sequencer is idle. A running pose
//   sample passes prep, the CORDIC loop (one rotation per cycle), the error
//   update, two multiplier passes (MULP, MULD) and the emit state, which loads
//   the output register. A stop result goes straight from idle to emit. Start
//   items and dropped poses leave the sequencer idle, so in_ready stays high.
// Stall: the result register holds until taken; a new input can be taken
//   while it waits, and the next result waits in the sequencer.
// Reset: registers go to their reset values, errors to pi, block disarmed.
// ----------------------------------------------------------------------------
module pd_heading_rotation_controller_core #(
  parameter int CORDIC_STEPS = pdhrc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pdhrc_pkg::pdhrc_in_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pdhrc_pkg::pdhrc_out_t     out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  pdhrc_pkg::pdhrc_state_t state_r, state_nxt;

  logic signed [31:0] target_x_r;
  logic signed [31:0] target_y_r;
  logic [15:0]        gain_p_r;
  logic [15:0]        gain_d_r;
  logic [14:0]        stop_thr_r;
  logic [15:0]        error_now_r;
  logic [15:0]        error_before_r;
  logic               armed_r;

  logic signed [pdhrc_pkg::DELTA_W-1:0] dx_r;
  logic signed [pdhrc_pkg::DELTA_W-1:0] dy_r;
  logic signed [15:0]                   yaw_r;
  logic                                 neg_r;
  logic                                 stop_r;
  logic signed [34:0]                   acc_r;
  logic signed [34:0]                   s_r;
  logic                                 out_valid_r;
  pdhrc_pkg::pdhrc_out_t                out_data_r;

  logic                                 in_fire;
  logic                                 is_pose;
  logic                                 stop_hit;
  logic                                 out_free;
  logic                                 cstart;
  pdhrc_pkg::pdhrc_cordic_stat_t        cstat;
  logic signed [pdhrc_pkg::BEAR_W-1:0]  bearing;
  logic signed [17:0]                   diff;
  logic [17:0]                          diff_mag;
  logic [15:0]                          err;
  logic                                 neg_sign;
  logic signed [16:0]                   delta;
  logic signed [16:0]                   mul_a;
  logic signed [16:0]                   mul_b;
  logic signed [33:0]                   prod;
  logic [34:0]                          s_abs;
  logic [34:0]                          s_rnd;
  logic [26:0]                          mag;
  logic                                 neg_out;
  logic signed [15:0]                   turn;

  pdhrc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cstart),
    .dx      (dx_r),
    .dy      (dy_r),
    .stat    (cstat),
    .bearing (bearing)
  );

  assign in_ready  = (state_r == pdhrc_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_pose   = (in_data.kind == pdhrc_pkg::KIND_POSE);
  assign stop_hit  = (error_now_r <= {1'b0, stop_thr_r});
  assign out_free  = !out_valid_r || out_ready;
  assign cstart    = (state_r == pdhrc_pkg::ST_PREP);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // heading error and turn direction
  assign diff     = 18'(bearing) - 18'(yaw_r);
  assign diff_mag = diff[17] ? 18'(-diff) : 18'(diff);
  assign err      = (diff_mag > 18'd65535) ? 16'hFFFF : diff_mag[15:0];
  assign neg_sign = ((err > pdhrc_pkg::PI_Q12) && !diff[17]) ||
                    ((err < pdhrc_pkg::PI_Q12) && diff[17]);

  // shared multiplier: gain_p*e, then gain_d*(e - e_prev)
  assign delta = $signed({1'b0, error_now_r}) - $signed({1'b0, error_before_r});
  assign mul_a = (state_r == pdhrc_pkg::ST_MULP) ? $signed({1'b0, gain_p_r})
                                                 : $signed({1'b0, gain_d_r});
  assign mul_b = (state_r == pdhrc_pkg::ST_MULP) ? $signed({1'b0, error_now_r})
                                                 : delta;
  assign prod  = mul_a * mul_b;

  // round half away from zero to Q4.12, apply direction, saturate
  assign s_abs   = s_r[34] ? 35'(-s_r) : 35'(s_r);
  assign s_rnd   = s_abs + 35'd128;
  assign mag     = s_rnd[34:8];
  assign neg_out = s_r[34] ^ neg_r;

  always_comb begin
    if (neg_out) begin
      turn = (mag > 27'd32768) ? 16'sh8000 : 16'(27'd0 - mag);
    end else begin
      turn = (mag > 27'd32767) ? 16'sh7FFF : $signed(mag[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdhrc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdhrc_pkg::ST_IDLE: begin
        if (in_fire && is_pose && armed_r) begin
          state_nxt = stop_hit ? pdhrc_pkg::ST_EMIT : pdhrc_pkg::ST_PREP;
        end
      end
      pdhrc_pkg::ST_PREP:   state_nxt = pdhrc_pkg::ST_ROTATE;
      pdhrc_pkg::ST_ROTATE: begin
        if (cstat.done) begin
          state_nxt = pdhrc_pkg::ST_MULP;
        end
      end
      pdhrc_pkg::ST_MULP:   state_nxt = pdhrc_pkg::ST_MULD;
      pdhrc_pkg::ST_MULD:   state_nxt = pdhrc_pkg::ST_EMIT;
      pdhrc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = pdhrc_pkg::ST_IDLE;
        end
      end
      default:              state_nxt = pdhrc_pkg::ST_IDLE;
    endcase
  end

  // configuration, controller state, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r     <= '0;
      target_y_r     <= '0;
      gain_p_r       <= 16'd77;
      gain_d_r       <= 16'd102;
      stop_thr_r     <= 15'd205;
      error_now_r    <= pdhrc_pkg::PI_Q12;
      error_before_r <= pdhrc_pkg::PI_Q12;
      armed_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pdhrc_pkg::REG_TARGET_X: target_x_r <= $signed(cfg_wdata);
          pdhrc_pkg::REG_TARGET_Y: target_y_r <= $signed(cfg_wdata);
          pdhrc_pkg::REG_GAIN_P:   gain_p_r   <= cfg_wdata[15:0];
          pdhrc_pkg::REG_GAIN_D:   gain_d_r   <= cfg_wdata[15:0];
          pdhrc_pkg::REG_STOP_THR: stop_thr_r <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (!is_pose) begin
          error_now_r    <= pdhrc_pkg::PI_Q12;
          error_before_r <= pdhrc_pkg::PI_Q12;
          armed_r        <= 1'b1;
        end else if (armed_r && stop_hit) begin
          armed_r <= 1'b0;
        end
      end
      if ((state_r == pdhrc_pkg::ST_ROTATE) && cstat.done) begin
        error_before_r <= error_now_r;
        error_now_r    <= err;
      end
      if ((state_r == pdhrc_pkg::ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_fire && is_pose && armed_r) begin
      if (stop_hit) begin
        stop_r <= 1'b1;
        s_r    <= '0;
      end else begin
        stop_r <= 1'b0;
        dx_r   <= {target_x_r[31], target_x_r} - {in_data.pos_x[31], in_data.pos_x};
        dy_r   <= {target_y_r[31], target_y_r} - {in_data.pos_y[31], in_data.pos_y};
        yaw_r  <= in_data.yaw;
      end
    end
    if ((state_r == pdhrc_pkg::ST_ROTATE) && cstat.done) begin
      neg_r <= neg_sign;
    end
    if (state_r == pdhrc_pkg::ST_MULP) begin
      acc_r <= 35'(prod);
    end
    if (state_r == pdhrc_pkg::ST_MULD) begin
      s_r <= acc_r + 35'(prod);
    end
    if ((state_r == pdhrc_pkg::ST_EMIT) && out_free) begin
      out_data_r.turn_rate <= turn;
      out_data_r.stopped   <= stop_r;
    end
  end

  // CORDIC is never restarted mid-rotation
  a_cordic_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cstart |-> !cstat.busy)
    else $error("CORDIC started while busy");

  // CORDIC completion is only seen while the sequencer waits for it
  a_cordic_done_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    cstat.done |-> (state_r == pdhrc_pkg::ST_ROTATE))
    else $error("CORDIC done outside rotate state");

  // disarming always queues a stop result
  a_disarm_stop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(armed_r) |-> ((state_r == pdhrc_pkg::ST_EMIT) && stop_r))
    else $error("disarmed without a stop result");

  // a stop result carries a zero command
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.stopped) |-> (out_data_r.turn_rate == 16'sd0))
    else $error("stop result with nonzero turn rate");

endmodule
`default_nettype wire

@@ rtl/core/pdhrc_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdhrc_cordic : iterative vectoring CORDIC for atan2(dy, dx)
// One micro-rotation per cycle through a shared shift/add stage; the result
// is the bearing in signed Q4.12 radians, valid while done is high.
// ----------------------------------------------------------------------------
module pdhrc_cordic #(
  parameter int CORDIC_STEPS = pdhrc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  input  wire logic signed [pdhrc_pkg::DELTA_W-1:0]    dx,
  input  wire logic signed [pdhrc_pkg::DELTA_W-1:0]    dy,
  output pdhrc_pkg::pdhrc_cordic_stat_t                stat,
  output logic signed [pdhrc_pkg::BEAR_W-1:0]          bearing
);

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

  logic                              busy_r;
  logic                              done_r;
  logic [CW-1:0]                     cnt_r;
  logic signed [pdhrc_pkg::XY_W-1:0] x_r;
  logic signed [pdhrc_pkg::XY_W-1:0] y_r;
  logic signed [pdhrc_pkg::Z_W-1:0]  z_r;
  logic                              zero_r;

  logic signed [pdhrc_pkg::XY_W-1:0] dx_ext;
  logic signed [pdhrc_pkg::XY_W-1:0] dy_ext;
  logic signed [pdhrc_pkg::XY_W-1:0] xs;
  logic signed [pdhrc_pkg::XY_W-1:0] ys;
  logic signed [pdhrc_pkg::Z_W-1:0]  ang;
  logic signed [pdhrc_pkg::Z_W-1:0]  z_rnd;
  logic [4:0]                        tab_idx;

  assign dx_ext  = pdhrc_pkg::XY_W'(dx);
  assign dy_ext  = pdhrc_pkg::XY_W'(dy);
  assign xs      = x_r >>> cnt_r;
  assign ys      = y_r >>> cnt_r;
  assign tab_idx = 5'(cnt_r);
  assign ang     = pdhrc_pkg::atan_q30(tab_idx);

  // round to Q4.12: floor((z + 2^17) / 2^18)
  assign z_rnd   = z_r + pdhrc_pkg::Z_W'(131072);
  assign bearing = zero_r ? '0 : z_rnd[pdhrc_pkg::Z_W-1:18];

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (dx == '0) && (dy == '0);
      if (dx < 0) begin
        // left half plane: rotate by pi first
        x_r <= -dx_ext;
        y_r <= -dy_ext;
        z_r <= (dy >= 0) ? pdhrc_pkg::PI_Q30 : -pdhrc_pkg::PI_Q30;
      end else begin
        x_r <= dx_ext;
        y_r <= dy_ext;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end
    end
  end

endmodule
`default_nettype wire

@@ verif/pd_heading_rotation_controller_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_heading_rotation_controller_core_test : heading controller testbench
// Drives start and pose transfers, predicts each turn command with a CORDIC
// bearing and PD law model, and compares every output transfer in order.
// Phases vary registers, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module pd_heading_rotation_controller_core_test;

  localparam int      STEPS       = 16;
  localparam longint  PI_RAD12    = 12868;
  localparam longint  PI_RAD30    = 64'sd3373259426;
  localparam int      CYCLE_LIMIT = 300000;
  localparam int      SETTLE      = 40;
  localparam int      PHASE_ITEMS = 170;

  // Heading model plus the queue of commands still owed by the block.
  class heading_scoreboard;
    longint                command_dummy_unused_guard;
    longint                tgt_x;
    longint                tgt_y;
    longint                kp;
    longint                kd;
    longint                thr;
    longint                err_now;
    longint                err_prev;
    bit                    armed;
    int                    errors;
    pdhrc_pkg::pdhrc_out_t command_q[$];

    function new();
      command_dummy_unused_guard = 0;
      tgt_x    = 0;
      tgt_y    = 0;
      kp       = 77;
      kd       = 102;
      thr      = 205;
      err_now  = PI_RAD12;
      err_prev = PI_RAD12;
      armed    = 0;
      errors   = 0;
    endfunction

    function void write_reg(pdhrc_pkg::pdhrc_reg_t idx, logic [31:0] v);
      case (idx)
        pdhrc_pkg::REG_TARGET_X: tgt_x = longint'($signed(v));
        pdhrc_pkg::REG_TARGET_Y: tgt_y = longint'($signed(v));
        pdhrc_pkg::REG_GAIN_P:   kp    = longint'(v[15:0]);
        pdhrc_pkg::REG_GAIN_D:   kd    = longint'(v[15:0]);
        pdhrc_pkg::REG_STOP_THR: thr   = longint'(v[14:0]);
        default: ;
      endcase
    endfunction

    function longint rotation_step(int i);
      case (i)
        0:  return 843314856;
        1:  return 497837829;
        2:  return 263043836;
        3:  return 133525158;
        4:  return 67021686;
        5:  return 33543515;
        6:  return 16775850;
        7:  return 8388437;
        8:  return 4194282;
        9:  return 2097149;
        10: return 1048575;
        11: return 524287;
        12: return 262143;
        13: return 131071;
        14: return 65535;
        15: return 32767;
        16: return 16383;
        17: return 8191;
        18: return 4095;
        19: return 2047;
        20: return 1023;
        21: return 511;
        22: return 255;
        23: return 127;
        default: return 0;
      endcase
    endfunction

    // atan2(dy, dx) in Q4.12; vectoring mode, left half-plane folded by pi
    function longint bearing(longint dx, longint dy);
      longint x, y, z, xs, ys;
      if (dx == 0 && dy == 0) return 0;
      x = dx;
      y = dy;
      z = 0;
      if (dx < 0) begin
        x = -dx;
        y = -dy;
        z = (dy >= 0) ? PI_RAD30 : -PI_RAD30;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + rotation_step(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - rotation_step(i);
        end
      end
      return (z + (longint'(1) <<< 17)) >>> 18;
    endfunction

    // Returns 1 unless the block is expected to drop the item.
    function bit take_sample(pdhrc_pkg::pdhrc_in_t it);
      longint                dx, dy, diff, mag, s, cmd;
      int                    dir;
      pdhrc_pkg::pdhrc_out_t r;
      if (it.kind == pdhrc_pkg::KIND_START) begin
        err_now  = PI_RAD12;
        err_prev = PI_RAD12;
        armed    = 1;
        return 1;
      end
      if (!armed) return 0;
      if (err_now <= thr) begin
        armed       = 0;
        r.turn_rate = '0;
        r.stopped   = 1'b1;
        command_q.push_back(r);
        return 1;
      end
      dx   = tgt_x - longint'($signed(it.pos_x));
      dy   = tgt_y - longint'($signed(it.pos_y));
      diff = bearing(dx, dy) - longint'($signed(it.yaw));
      mag  = (diff < 0) ? -diff : diff;
      if (mag > 65535) mag = 65535;
      err_prev = err_now;
      err_now  = mag;
      // shorter way round: flip when the error exceeds pi
      if (err_now > PI_RAD12 && diff > 0)      dir = -1;
      else if (err_now > PI_RAD12 && diff < 0) dir = 1;
      else if (err_now < PI_RAD12 && diff < 0) dir = -1;
      else                                     dir = 1;
      s   = kp * err_now + kd * (err_now - err_prev);
      mag = (s < 0) ? -s : s;
      mag = (mag + 128) >>> 8;
      cmd = (s < 0) ? -mag : mag;
      if (dir < 0) cmd = -cmd;
      if (cmd > 32767)  cmd = 32767;
      if (cmd < -32768) cmd = -32768;
      r.turn_rate = cmd[15:0];
      r.stopped   = 1'b0;
      command_q.push_back(r);
      return 1;
    endfunction

    function void check_command(pdhrc_pkg::pdhrc_out_t got);
      pdhrc_pkg::pdhrc_out_t exp;
      if (command_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, got turn_rate=%0d stopped=%0b",
                 $time, got.turn_rate, got.stopped);
        return;
      end
      exp = command_q.pop_front();
      if (got.turn_rate !== exp.turn_rate || got.stopped !== exp.stopped) begin
        errors++;
        $display({"%0t: mismatch, expected turn_rate=%0d stopped=%0b,",
                  " got turn_rate=%0d stopped=%0b"},
                 $time, exp.turn_rate, exp.stopped, got.turn_rate, got.stopped);
      end
    endfunction

    function int pending();
      return command_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pdhrc_pkg::pdhrc_in_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pdhrc_pkg::pdhrc_out_t out_data;
  logic                  cfg_we    = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [31:0]           cfg_wdata = '0;

  heading_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_asked    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int sent_items    = 0;
  int cycle_count   = 0;

  pd_heading_rotation_controller_core #(
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pd_heading_rotation_controller_core_test: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_command(out_data);
  end

  task automatic send_item(input pdhrc_pkg::pdhrc_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(sb.take_sample(it));
    sent_items++;
  endtask

  task automatic cfg_write(input pdhrc_pkg::pdhrc_reg_t idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] tx, input logic [31:0] ty,
                              input logic [15:0] gp, input logic [15:0] gd,
                              input logic [14:0] thr);
    cfg_write(pdhrc_pkg::REG_TARGET_X, tx);
    cfg_write(pdhrc_pkg::REG_TARGET_Y, ty);
    cfg_write(pdhrc_pkg::REG_GAIN_P, {16'b0, gp});
    cfg_write(pdhrc_pkg::REG_GAIN_D, {16'b0, gd});
    cfg_write(pdhrc_pkg::REG_STOP_THR, {17'b0, thr});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every owed command, then let a start or dropped pose finish.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic pdhrc_pkg::pdhrc_in_t make_item(input logic kind,
                                                     input logic [31:0] x,
                                                     input logic [31:0] y,
                                                     input logic [15:0] yaw);
    pdhrc_pkg::pdhrc_in_t it;
    it.kind  = kind;
    it.pos_x = x;
    it.pos_y = y;
    it.yaw   = yaw;
    return it;
  endfunction

  // Heading that points at the target from (x, y), off by at most spread.
  function automatic logic [15:0] aimed_yaw(input logic [31:0] x, input logic [31:0] y,
                                            input int spread);
    longint b;
    longint d;
    b = sb.bearing(sb.tgt_x - longint'($signed(x)), sb.tgt_y - longint'($signed(y)));
    d = longint'($urandom_range(2 * spread)) - spread;
    return 16'(b + d);
  endfunction

  function automatic logic [31:0] rand_coord(input longint base);
    int off;
    off = $urandom_range(255);
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(2097152)) - 32'd1048576;
      2: return 32'(base) + 32'(off) - 32'd128;
      default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // Start, a few poses off target; in 9 of 10 runs, poses on target to a stop.
  task automatic run_rotation();
    logic [31:0] x, y;
    int          spread;
    int          far_n;
    bit          broken;
    far_n  = $urandom_range(4);
    broken = ($urandom_range(9) == 0);
    spread = (sb.thr < 4000) ? int'(sb.thr) : 4000;
    send_item(make_item(pdhrc_pkg::KIND_START, $urandom, $urandom, 16'($urandom)));
    repeat (far_n) begin
      send_item(make_item(pdhrc_pkg::KIND_POSE, rand_coord(sb.tgt_x),
                          rand_coord(sb.tgt_y), 16'($urandom)));
    end
    if (!broken) begin
      repeat ($urandom_range(1, 2)) begin
        x = rand_coord(sb.tgt_x);
        y = rand_coord(sb.tgt_y);
        send_item(make_item(pdhrc_pkg::KIND_POSE, x, y, aimed_yaw(x, y, spread)));
      end
      send_item(make_item(pdhrc_pkg::KIND_POSE, rand_coord(sb.tgt_x),
                          rand_coord(sb.tgt_y), 16'($urandom)));
    end
  endtask

  initial begin
    logic [15:0] b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers, target at the origin
    // dropped while disarmed
    send_item(make_item(pdhrc_pkg::KIND_POSE, $urandom, $urandom, 16'($urandom)));
    send_item(make_item(pdhrc_pkg::KIND_START, '0, '0, '0));
    // on the target
    send_item(make_item(pdhrc_pkg::KIND_POSE, '0, '0, 16'($urandom)));
    send_item(make_item(pdhrc_pkg::KIND_POSE, 32'h7fff_ffff, 32'h8000_0000, 16'h8000));
    // restart
    send_item(make_item(pdhrc_pkg::KIND_START, 32'hffff_ffff, 32'hffff_ffff, 16'hffff));
    b = aimed_yaw(32'hffff_0000, 32'h0001_0000, 0);
    send_item(make_item(pdhrc_pkg::KIND_POSE, 32'hffff_0000, 32'h0001_0000,
                        b - 16'(PI_RAD12)));
    send_item(make_item(pdhrc_pkg::KIND_POSE, 32'hffff_0000, 32'h0001_0000,
                        b + 16'(PI_RAD12)));
    send_item(make_item(pdhrc_pkg::KIND_POSE, 32'h0000_0001, 32'h8000_0000, 16'h7fff));
    send_item(make_item(pdhrc_pkg::KIND_POSE, 32'h0001_0000, 32'h0002_0000,
                        aimed_yaw(32'h0001_0000, 32'h0002_0000, 0)));
    // stop, then dropped
    send_item(make_item(pdhrc_pkg::KIND_POSE, $urandom, $urandom, 16'($urandom)));
    send_item(make_item(pdhrc_pkg::KIND_POSE, $urandom, $urandom, 16'($urandom)));
    wait_drain();

    apply_config(32'h7fff_ffff, 32'h8000_0000, 16'hffff, 16'hffff, 15'd0);
    send_item(make_item(pdhrc_pkg::KIND_START, '0, '0, '0));
    send_item(make_item(pdhrc_pkg::KIND_POSE, 32'h8000_0000, 32'h7fff_ffff, 16'h8000));
    send_item(make_item(pdhrc_pkg::KIND_POSE, 32'h8000_0000, 32'h7fff_ffff,
                        aimed_yaw(32'h8000_0000, 32'h7fff_ffff, 0)));
    // stop
    send_item(make_item(pdhrc_pkg::KIND_POSE, 32'h8000_0000, 32'h7fff_ffff, 16'h7fff));
    wait_drain();

    apply_config('0, '0, '0, '0, 15'd0);
    send_item(make_item(pdhrc_pkg::KIND_START, '0, '0, '0));
    send_item(make_item(pdhrc_pkg::KIND_POSE, '0, '0, '0));
    // stop
    send_item(make_item(pdhrc_pkg::KIND_POSE, '0, '0, 16'h1234));
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          apply_config($urandom, $urandom, 16'd77, 16'd102, 15'd205);
        end
        1: begin
          send_idle_pct = 75;
          stall_pct     = 0;
          apply_config($urandom, $urandom, 16'd0, 16'hffff, 15'h7fff);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 75;
          apply_config($urandom_range(65535), $urandom_range(65535), 16'hffff, 16'd0, 15'd0);
        end
        default: begin
          send_idle_pct = 24;
          stall_pct     = 24;
          apply_config($urandom, $urandom, 16'($urandom), 16'($urandom),
                       15'($urandom_range(2000)));
        end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 0) hold_asked++;
      sent_items = 0;
      while (sent_items < PHASE_ITEMS) begin
        if ($urandom_range(9) < 7) begin
          run_rotation();
        end else begin
          send_item(make_item(1'($urandom_range(1)), rand_coord(sb.tgt_x),
                              rand_coord(sb.tgt_y), 16'($urandom)));
        end
      end
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pd_heading_rotation_controller_core_test: PASS");
    end else begin
      $display("pd_heading_rotation_controller_core_test: FAIL");
    end
    $finish;
  end

endmodule
